FILE: rtl/sorted_address_table_core_macros.svh
// Assertion macros for the sorted address table.
`ifndef SORTED_ADDRESS_TABLE_CORE_MACROS_SVH
`define SORTED_ADDRESS_TABLE_CORE_MACROS_SVH
`define SAT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sorted address table check failed");
`define SAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sorted address table check failed");
`endif

FILE: rtl/sat_pkg.sv
package sat_pkg;
	localparam int ADDR_W = 32;
	localparam int POS_W = 11;
	localparam int TAG_W = 16;
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;
	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_DUP = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic operation;
		logic [ADDR_W-1:0] address;
		logic [TAG_W-1:0] name_tag;
	} in_item_t;

	typedef struct packed {
		logic found;
		logic [POS_W-1:0] position;
		logic [TAG_W-1:0] tag_out;
		logic [1:0] status;
	} out_item_t;

	typedef enum logic [2:0] {
		S_IDLE, S_SEARCH, S_READ, S_CHECK, S_SHIFT_RD, S_SHIFT_WR, S_WRITE, S_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic search_init;
		logic search_read;
		logic search_step;
		logic probe_read;
		logic shift_read;
		logic shift_write;
		logic final_write;
		logic result_load;
	} cmd_t;

	typedef struct packed {
		logic search_done;
		logic hit;
		logic full;
		logic is_insert;
		logic shift_done;
	} sts_t;
endpackage

FILE: rtl/sat_ctrl.sv
module sat_ctrl
	import sat_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input logic out_stall,
	input sts_t sts,
	output cmd_t cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					cmd.search_init = 1'b1;
					state_d = S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (sts.search_done) begin
					cmd.probe_read = 1'b1;
					state_d = S_CHECK;
				end else begin
					cmd.search_read = 1'b1;
					state_d = S_READ;
				end
			end
			S_READ: begin
				cmd.search_step = 1'b1;
				state_d = S_SEARCH;
			end
			S_CHECK: begin
				if (sts.is_insert && !sts.hit && !sts.full) begin
					state_d = S_SHIFT_RD;
				end else begin
					cmd.result_load = 1'b1;
					state_d = S_OUT;
				end
			end
			S_SHIFT_RD: begin
				if (sts.shift_done) begin
					cmd.final_write = 1'b1;
					state_d = S_WRITE;
				end else begin
					cmd.shift_read = 1'b1;
					state_d = S_SHIFT_WR;
				end
			end
			S_SHIFT_WR: begin
				cmd.shift_write = 1'b1;
				state_d = S_SHIFT_RD;
			end
			S_WRITE: begin
				cmd.result_load = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

FILE: rtl/sat_datapath.sv
module sat_datapath
	import sat_pkg::*;
#(
	parameter int CAPACITY = 1024,
	parameter int TAG_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input in_item_t in_item,
	input cmd_t cmd,
	output sts_t sts,
	output out_item_t out_item
);
	localparam int IW = $clog2(CAPACITY);
	localparam int CW = IW + 1;

	logic [ADDR_W-1:0] key_mem [CAPACITY];
	logic [TAG_BITS-1:0] tag_mem [CAPACITY];

	in_item_t item_q;
	logic [CW-1:0] count_q, lo_q, hi_q, idx_q;
	logic [ADDR_W-1:0] rd_key_q;
	logic [TAG_BITS-1:0] rd_tag_q;
	logic hit_q;
	logic full_q;
	out_item_t out_q;
	logic [CW-1:0] mid, rd_addr;
	logic [CW-1:0] idx_m1;

	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	assign idx_m1 = idx_q - CW'(1);

	always_comb begin
		if (cmd.shift_read) begin
			rd_addr = idx_m1;
		end else if (cmd.probe_read) begin
			rd_addr = lo_q;
		end else begin
			rd_addr = mid;
		end
	end

	always_ff @(posedge clk) begin
		rd_key_q <= key_mem[rd_addr[IW-1:0]];
		rd_tag_q <= tag_mem[rd_addr[IW-1:0]];
		if (cmd.shift_write) begin
			key_mem[idx_q[IW-1:0]] <= rd_key_q;
			tag_mem[idx_q[IW-1:0]] <= rd_tag_q;
		end else if (cmd.final_write) begin
			key_mem[lo_q[IW-1:0]] <= item_q.address;
			tag_mem[lo_q[IW-1:0]] <= TAG_BITS'(item_q.name_tag);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.final_write) begin
			count_q <= count_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_item;
		end
		if (cmd.search_init) begin
			lo_q <= '0;
			hi_q <= count_q;
		end else if (cmd.search_step) begin
			if (rd_key_q < item_q.address) begin
				lo_q <= mid + CW'(1);
			end else begin
				hi_q <= mid;
			end
		end
		if (cmd.probe_read) begin
			hit_q <= lo_q < count_q;
			full_q <= count_q >= CW'(CAPACITY);
			idx_q <= count_q;
		end else if (cmd.shift_write) begin
			idx_q <= idx_m1;
		end
		if (cmd.result_load) begin
			out_q.found <= sts.hit;
			out_q.position <= POS_W'(lo_q);
			out_q.tag_out <= sts.hit ? TAG_W'(rd_tag_q) : '0;
			if (item_q.operation == OP_LOOKUP) begin
				out_q.status <= ST_DONE;
			end else if (sts.hit) begin
				out_q.status <= ST_DUP;
			end else if (sts.full) begin
				out_q.status <= ST_FULL;
			end else begin
				out_q.status <= ST_DONE;
			end
		end
	end

	assign sts.search_done = !(lo_q < hi_q);
	assign sts.hit = hit_q && (rd_key_q == item_q.address);
	assign sts.full = full_q;
	assign sts.is_insert = item_q.operation == OP_INSERT;
	assign sts.shift_done = !(idx_q > lo_q);
	assign out_item = out_q;
endmodule

FILE: rtl/sorted_address_table_core.sv
// Sorted address table with binary search lookup and shifting insert.
// An item is loaded, binary searched and probed at its position; a new insert into a
// non-full table shifts the entries above up, then is written. One item at a time.
// The search and the shift share the single read port of the key and tag memories.
// Reset clears the entry count and the controller; memory contents are not cleared.
`include "sorted_address_table_core_macros.svh"
module sorted_address_table_core
	import sat_pkg::*;
#(
	parameter int CAPACITY = 1024,
	parameter int TAG_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output out_item_t out_data
);
	cmd_t cmd;
	sts_t sts;

	sat_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
	);

	sat_datapath #(.CAPACITY(CAPACITY), .TAG_BITS(TAG_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_data), .cmd(cmd),
		.sts(sts), .out_item(out_data)
	);

	`SAT_ASSERT_IMPL(a_no_accept_busy, clk, arst_n, out_valid, in_stall)
	`SAT_ASSERT_IMPL(a_full_not_ok, clk, arst_n, out_valid && out_data.status == ST_FULL, !out_data.found)
	`SAT_ASSERT_NEXT(a_accept_no_out, clk, arst_n, in_valid && !in_stall, !out_valid)
endmodule
